// ----- design/plin_pkg.sv -----
// Package for the piecewise linear interpolator: item and point types,
// codes, state encoding and default sizes. Used by plin_mdu and the top level.
package plin_pkg;

    localparam int DEF_TABLE_DEPTH = 64;
    localparam int DEF_FRAC_BITS   = 16;

    // Width of a difference of two 32-bit signed values
    localparam int DIFF_W  = 33;
    localparam int COUNT_W = 7;
    localparam int PADDR_W = 3;

    localparam logic       ACT_LOAD  = 1'b0;
    localparam logic       ACT_QUERY = 1'b1;

    localparam logic [1:0] STAT_OK  = 2'd0;
    localparam logic [1:0] STAT_FEW = 2'd1;
    localparam logic [1:0] STAT_SAT = 2'd2;

    localparam logic       REG_POINT_COUNT = 1'b0;

    typedef struct packed {
        logic               action;
        logic [5:0]         entry_index;
        logic signed [31:0] entry_x;
        logic signed [31:0] entry_y;
        logic signed [31:0] query_x;
    } plin_in_t;

    typedef struct packed {
        logic signed [31:0] interp_y;
        logic [1:0]         status;
    } plin_out_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } plin_point_t;

    typedef enum logic {
        MDU_DIV,
        MDU_MUL
    } plin_mdu_op_t;

    typedef struct packed {
        logic         start;
        plin_mdu_op_t op;
    } plin_mdu_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIRST,
        ST_LAST,
        ST_SCAN,
        ST_GETA,
        ST_GETB,
        ST_PREP,
        ST_CHECK,
        ST_DIV,
        ST_MUL,
        ST_FIN,
        ST_DONE
    } plin_state_t;

endpackage

// ----- design/plin_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module plin_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/plin_mdu.sv -----
// Shared shift/add unit: restoring divide of (a << FRAC_BITS) by b, then
// shift-add multiply of the quotient by a new a, one bit per cycle.
// Depends on plin_pkg.
module plin_mdu import plin_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  plin_mdu_cmd_t                       cmd,
    input  logic [DIFF_W-1:0]                   opa,
    input  logic [DIFF_W-1:0]                   opb,
    output logic                                busy,
    output logic [2*DIFF_W+FRAC_BITS-1:0]       prod
);

    localparam int QW   = DIFF_W + FRAC_BITS;
    localparam int AW   = QW + 1;
    localparam int SW   = AW + 1;
    localparam int CNTW = $clog2(QW + 1);

    plin_mdu_op_t      op_reg;
    logic [CNTW-1:0]   cnt_reg;
    logic [QW-1:0]     acc_reg;
    logic [QW-1:0]     num_reg;
    logic [DIFF_W-1:0] den_reg;
    logic [DIFF_W-1:0] mul_reg;

    logic [DIFF_W:0]   rem_sh;
    logic [AW-1:0]     add_a;
    logic [AW-1:0]     add_b;
    logic              add_ci;
    logic [SW-1:0]     add_s;
    logic              ge;

    assign rem_sh = {acc_reg[DIFF_W-1:0], num_reg[QW-1]};

    always_comb begin
        if (op_reg == MDU_DIV) begin
            add_a  = AW'(rem_sh);
            add_b  = ~AW'(den_reg);
            add_ci = 1'b1;
        end else begin
            add_a  = AW'(acc_reg);
            add_b  = mul_reg[0] ? AW'(num_reg) : '0;
            add_ci = 1'b0;
        end
        add_s = {1'b0, add_a} + {1'b0, add_b} + SW'(add_ci);
    end

    assign ge = add_s[AW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg  <= MDU_DIV;
            cnt_reg <= '0;
        end else if (cmd.start) begin
            op_reg  <= cmd.op;
            cnt_reg <= (cmd.op == MDU_DIV) ? CNTW'(QW) : CNTW'(DIFF_W);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - CNTW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            acc_reg <= '0;
            if (cmd.op == MDU_DIV) begin
                num_reg <= QW'(opa) << FRAC_BITS;
                den_reg <= opb;
            end else begin
                mul_reg <= opa;
            end
        end else if (cnt_reg != '0) begin
            if (op_reg == MDU_DIV) begin
                acc_reg <= ge ? QW'(add_s[DIFF_W-1:0]) : QW'(rem_sh[DIFF_W-1:0]);
                num_reg <= {num_reg[QW-2:0], ge};
            end else begin
                acc_reg <= add_s[QW:1];
                mul_reg <= {add_s[0], mul_reg[DIFF_W-1:1]};
            end
        end
    end

    assign busy = (cnt_reg != '0);
    assign prod = {acc_reg, mul_reg};

endmodule

// ----- design/piecewise_linear_interpolator.sv -----
// Piecewise linear interpolator, top level: breakpoint RAM, sequencer, APB register.
// Depends on plin_pkg, plin_ram and plin_mdu.
//
// A load item is written to the breakpoint RAM as it is taken. A query reads the first point
// and, unless x lies at or below it, the last point. If x lies between them, it scans
// the table one point per cycle from index zero until a segment brackets x. It then
// runs 33+FRAC_BITS divide steps and 33 multiply steps on the one shared shift/add unit.
// A query with fewer than two points, equal x ends or no bracketing segment finishes
// early. A query's result waits in the done state while the previous result is still
// held on the m_ channel. The next item is taken while a finished result still waits
// on the m_ channel.
module piecewise_linear_interpolator import plin_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  plin_in_t           s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output plin_out_t          m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int NW    = $clog2(TABLE_DEPTH + 1);
    localparam int PW    = 2 * DIFF_W + FRAC_BITS;
    localparam int RW    = DIFF_W + 2;
    localparam logic [31:0] Y_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Y_MIN = 32'h8000_0000;

    function automatic logic [DIFF_W-1:0] mag(input logic [DIFF_W-1:0] v);
        return v[DIFF_W-1] ? (~v + DIFF_W'(1)) : v;
    endfunction

    plin_state_t        state_reg, state_next;
    logic [COUNT_W-1:0] count_reg;
    logic signed [31:0] x_reg, x_next;
    plin_point_t        pa_reg, pa_next;
    plin_point_t        pb_reg, pb_next;
    logic [AW-1:0]      scan_reg, scan_next;
    logic [DIFF_W-1:0]  dx_reg, dx_next;
    logic [DIFF_W-1:0]  dxs_reg, dxs_next;
    logic [DIFF_W-1:0]  dy_reg, dy_next;
    logic               neg_reg, neg_next;
    logic [31:0]        res_y_reg, res_y_next;
    logic [1:0]         res_st_reg, res_st_next;
    logic               m_valid_reg, m_valid_next;
    plin_out_t          m_data_reg, m_data_next;

    logic [NW-1:0]      n_eff;
    logic               few;
    logic [AW-1:0]      last_addr;
    logic [AW-1:0]      last2_addr;
    logic               ram_we;
    logic [AW-1:0]      ram_raddr;
    logic [63:0]        ram_rdata;
    plin_point_t        rd;
    logic               idx_ok;
    logic               cfg_wr;

    plin_mdu_cmd_t      mdu_cmd;
    logic [DIFF_W-1:0]  mdu_opa;
    logic [DIFF_W-1:0]  mdu_opb;
    logic               mdu_busy;
    logic [PW-1:0]      mdu_prod;

    logic [2*DIFF_W-1:0] t_full;
    logic               t_big;
    logic [RW-1:0]      y0w;
    logic [RW-1:0]      r_sum;
    logic               r_ovf;

    assign n_eff      = (32'(count_reg) > TABLE_DEPTH) ? NW'(TABLE_DEPTH) : NW'(count_reg);
    assign few        = (n_eff < NW'(2));
    assign last_addr  = AW'(n_eff - NW'(1));
    assign last2_addr = AW'(n_eff - NW'(2));
    assign idx_ok     = (32'(s_data.entry_index) < TABLE_DEPTH);
    assign rd         = ram_rdata;

    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[PADDR_W-1:2] == REG_POINT_COUNT);
    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_W-1:2] == REG_POINT_COUNT) ? 32'(count_reg) : '0;

    plin_ram #(
        .WIDTH (64),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (AW'(s_data.entry_index)),
        .wdata ({s_data.entry_x, s_data.entry_y}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    plin_mdu #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mdu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (mdu_cmd),
        .opa     (mdu_opa),
        .opb     (mdu_opb),
        .busy    (mdu_busy),
        .prod    (mdu_prod)
    );

    assign t_full = mdu_prod[PW-1:FRAC_BITS];
    assign t_big  = |t_full[2*DIFF_W-1:DIFF_W];
    assign y0w    = RW'(pa_reg.y) | {{(RW-32){pa_reg.y[31]}}, 32'h0};
    assign r_sum  = neg_reg ? (y0w - RW'(t_full[DIFF_W-1:0]))
                            : (y0w + RW'(t_full[DIFF_W-1:0]));
    assign r_ovf  = !((r_sum[RW-1:31] == '0) || (r_sum[RW-1:31] == '1));

    always_comb begin
        state_next   = state_reg;
        x_next       = x_reg;
        pa_next      = pa_reg;
        pb_next      = pb_reg;
        scan_next    = scan_reg;
        dx_next      = dx_reg;
        dxs_next     = dxs_reg;
        dy_next      = dy_reg;
        neg_next     = neg_reg;
        res_y_next   = res_y_reg;
        res_st_next  = res_st_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        ram_we       = 1'b0;
        ram_raddr    = '0;
        mdu_cmd      = '{start: 1'b0, op: MDU_DIV};
        mdu_opa      = mag(dx_reg);
        mdu_opb      = mag(dxs_reg);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_data.action == ACT_LOAD) begin
                        ram_we = idx_ok;
                    end else begin
                        x_next = s_data.query_x;
                        if (few) begin
                            res_y_next  = '0;
                            res_st_next = STAT_FEW;
                            state_next  = ST_DONE;
                        end else begin
                            ram_raddr  = '0;
                            state_next = ST_FIRST;
                        end
                    end
                end
            end
            ST_FIRST: begin
                if (x_reg <= rd.x) begin
                    pa_next    = rd;
                    ram_raddr  = AW'(1);
                    state_next = ST_GETB;
                end else begin
                    ram_raddr  = last_addr;
                    state_next = ST_LAST;
                end
            end
            ST_LAST: begin
                if (x_reg >= rd.x) begin
                    pb_next    = rd;
                    ram_raddr  = last2_addr;
                    state_next = ST_GETA;
                end else begin
                    ram_raddr  = '0;
                    scan_next  = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_reg == '0) begin
                    pa_next   = rd;
                    scan_next = scan_reg + AW'(1);
                    ram_raddr = scan_reg + AW'(1);
                end else if (x_reg >= pa_reg.x && x_reg <= rd.x) begin
                    pb_next    = rd;
                    state_next = ST_PREP;
                end else if (scan_reg == last_addr) begin
                    res_y_next  = '0;
                    res_st_next = STAT_OK;
                    state_next  = ST_DONE;
                end else begin
                    pa_next   = rd;
                    scan_next = scan_reg + AW'(1);
                    ram_raddr = scan_reg + AW'(1);
                end
            end
            ST_GETA: begin
                pa_next    = rd;
                state_next = ST_PREP;
            end
            ST_GETB: begin
                pb_next    = rd;
                state_next = ST_PREP;
            end
            ST_PREP: begin
                dxs_next   = {pb_reg.x[31], pb_reg.x} - {pa_reg.x[31], pa_reg.x};
                dx_next    = {x_reg[31], x_reg} - {pa_reg.x[31], pa_reg.x};
                dy_next    = {pb_reg.y[31], pb_reg.y} - {pa_reg.y[31], pa_reg.y};
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                neg_next = dx_reg[DIFF_W-1] ^ dxs_reg[DIFF_W-1] ^ dy_reg[DIFF_W-1];
                if (dxs_reg == '0) begin
                    res_y_next  = pa_reg.y;
                    res_st_next = STAT_OK;
                    state_next  = ST_DONE;
                end else begin
                    mdu_cmd    = '{start: 1'b1, op: MDU_DIV};
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                mdu_opa = mag(dy_reg);
                if (!mdu_busy) begin
                    mdu_cmd    = '{start: 1'b1, op: MDU_MUL};
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (!mdu_busy) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (t_big) begin
                    res_y_next  = neg_reg ? Y_MIN : Y_MAX;
                    res_st_next = STAT_SAT;
                end else if (r_ovf) begin
                    res_y_next  = r_sum[RW-1] ? Y_MIN : Y_MAX;
                    res_st_next = STAT_SAT;
                end else begin
                    res_y_next  = r_sum[31:0];
                    res_st_next = STAT_OK;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{interp_y: res_y_reg, status: res_st_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr) begin
                count_reg <= pwdata[COUNT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        x_reg      <= x_next;
        pa_reg     <= pa_next;
        pb_reg     <= pb_next;
        scan_reg   <= scan_next;
        dx_reg     <= dx_next;
        dxs_reg    <= dxs_next;
        dy_reg     <= dy_next;
        neg_reg    <= neg_next;
        res_y_reg  <= res_y_next;
        res_st_reg <= res_st_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the done state");

    a_unit_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !mdu_busy)
        else $error("shared unit busy while waiting for an item");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (scan_reg <= last_addr))
        else $error("scan ran past the last point");

endmodule
